/* sv/derangement_enumerator_top_macros.svh */
// assertion macros for the derangement enumerator checker
// both sample on clk; the first one is held off while rst_n is low
`ifndef DERANGEMENT_ENUMERATOR_TOP_MACROS_SVH
`define DERANGEMENT_ENUMERATOR_TOP_MACROS_SVH

`define DERANG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DERANG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/derang_pkg.sv */
// ----------------------------------------------------------------------------
// derang_pkg
// Shared constants and controller/datapath interface types for the
// derangement enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package derang_pkg;

    localparam int          MAX_ITEMS_DEF    = 8;
    localparam int          FIELD_W          = 4;
    localparam logic [3:0]  ITEM_COUNT_RESET = 4'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic emit;
        logic exhaust;
    } derang_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic skip;
        logic full;
        logic fail;
        logic out_free;
        logic emit_last;
    } derang_status_t;

endpackage

`default_nettype wire

/* sv/derang_ctrl.sv */
// ----------------------------------------------------------------------------
// derang_ctrl
// Request sequencer: accepts a request, runs the backtracking walk one
// step per cycle, then streams the result words or a single exhausted word.
// ----------------------------------------------------------------------------
`default_nettype none

module derang_ctrl import derang_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output derang_cmd_t         cmd,
    input  wire derang_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_EXH  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.skip ? ST_EXH : ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (status.full)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.fail)
                begin
                    state_next = ST_EXH;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EXH:
            begin
                if (status.out_free)
                begin
                    cmd.exhaust = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* sv/derang_dp.sv */
// ----------------------------------------------------------------------------
// derang_dp
// Walk datapath: slot stack, used mask, candidate pick, count register and
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module derang_dp import derang_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wen,
    input  wire logic [FIELD_W-1:0]     cfg_wdata,
    input  wire logic                   restart,
    input  wire derang_cmd_t            cmd,
    output derang_status_t              status,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2*FIELD_W-1:0]        out_data,
    output logic                        out_last,
    output logic                        out_exh
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int DW = $clog2(MAX_ITEMS + 1);
    localparam int CW = $clog2(MAX_ITEMS + 2);
    localparam logic [FIELD_W-1:0] MAX4 = FIELD_W'(MAX_ITEMS);

    logic [FIELD_W-1:0] slot_reg [MAX_ITEMS];

    logic [FIELD_W-1:0] item_count_reg, item_count_next;
    logic [MAX_ITEMS:0] used_reg, used_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [CW-1:0]      cand_reg, cand_next;
    logic               started_reg, started_next;
    logic               done_reg, done_next;
    logic [IW-1:0]      out_idx_reg, out_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] out_pos_reg, out_val_reg;
    logic               out_last_reg, out_exh_reg;

    logic [FIELD_W-1:0] n4;
    logic [DW-1:0]      n;
    logic [DW-1:0]      n_m1;
    logic [DW-1:0]      depth_m1;
    logic [CW-1:0]      depth_p1;
    logic [IW-1:0]      rd_idx;
    logic [FIELD_W-1:0] rd_val;
    logic               pick_ok;
    logic [FIELD_W-1:0] pick_v;
    logic               emit_last;
    logic               out_free;
    logic               out_load;

    always_comb
    begin
        if (item_count_reg == '0)
        begin
            n4 = FIELD_W'(1);
        end
        else if (item_count_reg > MAX4)
        begin
            n4 = MAX4;
        end
        else
        begin
            n4 = item_count_reg;
        end
    end

    assign n        = n4[DW-1:0];
    assign n_m1     = n - DW'(1);
    assign depth_m1 = depth_reg - DW'(1);
    assign depth_p1 = CW'(depth_reg) + CW'(1);

    always_comb
    begin
        priority if (cmd.start)
        begin
            rd_idx = n_m1[IW-1:0];
        end
        else if (cmd.step)
        begin
            rd_idx = depth_m1[IW-1:0];
        end
        else
        begin
            rd_idx = out_idx_reg;
        end
    end

    assign rd_val = slot_reg[rd_idx];

    // lowest free value at or above the candidate, skipping the own position
    always_comb
    begin
        pick_ok = 1'b0;
        pick_v  = '0;
        for (int v = MAX_ITEMS; v >= 1; v--)
        begin
            if ((CW'(v) >= cand_reg) && (DW'(v) <= n) && !used_reg[v]
                && (CW'(v) != depth_p1))
            begin
                pick_ok = 1'b1;
                pick_v  = FIELD_W'(v);
            end
        end
    end

    assign emit_last = ((DW'(out_idx_reg) + DW'(1)) == n);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = cmd.emit || cmd.exhaust;

    always_comb
    begin
        status.skip      = done_reg && !restart;
        status.full      = pick_ok && (depth_p1 == CW'(n));
        status.fail      = !pick_ok && (depth_reg == '0);
        status.out_free  = out_free;
        status.emit_last = emit_last;
    end

    always_comb
    begin
        item_count_next = item_count_reg;
        used_next       = used_reg;
        depth_next      = depth_reg;
        cand_next       = cand_reg;
        started_next    = started_reg;
        done_next       = done_reg;
        out_idx_next    = out_idx_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_wen)
        begin
            item_count_next = cfg_wdata;
            started_next    = 1'b0;
            done_next       = 1'b0;
        end

        if (cmd.start)
        begin
            out_idx_next = '0;
            if (restart || !started_reg)
            begin
                used_next    = '0;
                depth_next   = '0;
                cand_next    = CW'(1);
                started_next = 1'b1;
                done_next    = 1'b0;
            end
            else if (!done_reg)
            begin
                depth_next                = n_m1;
                used_next[rd_val[DW-1:0]] = 1'b0;
                cand_next                 = CW'(rd_val) + CW'(1);
            end
        end

        if (cmd.step)
        begin
            if (pick_ok)
            begin
                used_next[pick_v[DW-1:0]] = 1'b1;
                depth_next                = depth_reg + DW'(1);
                cand_next                 = CW'(1);
            end
            else if (depth_reg != '0)
            begin
                depth_next                = depth_m1;
                used_next[rd_val[DW-1:0]] = 1'b0;
                cand_next                 = CW'(rd_val) + CW'(1);
            end
            else
            begin
                done_next = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            out_idx_next = emit_last ? '0 : out_idx_reg + IW'(1);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= ITEM_COUNT_RESET;
            used_reg       <= '0;
            depth_reg      <= '0;
            cand_reg       <= CW'(1);
            started_reg    <= 1'b0;
            done_reg       <= 1'b0;
            out_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_count_reg <= item_count_next;
            used_reg       <= used_next;
            depth_reg      <= depth_next;
            cand_reg       <= cand_next;
            started_reg    <= started_next;
            done_reg       <= done_next;
            out_idx_reg    <= out_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // slot stack and output word, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.step && pick_ok)
        begin
            slot_reg[depth_reg[IW-1:0]] <= pick_v;
        end
        if (cmd.emit)
        begin
            out_pos_reg  <= FIELD_W'(out_idx_reg) + FIELD_W'(1);
            out_val_reg  <= rd_val;
            out_last_reg <= emit_last;
            out_exh_reg  <= 1'b0;
        end
        else if (cmd.exhaust)
        begin
            out_pos_reg  <= '0;
            out_val_reg  <= '0;
            out_last_reg <= 1'b1;
            out_exh_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {out_val_reg, out_pos_reg};
    assign out_last  = out_last_reg;
    assign out_exh   = out_exh_reg;

endmodule

`default_nettype wire

/* sv/derangement_enumerator_top.sv */
// ----------------------------------------------------------------------------
// derangement_enumerator_top
// Lists the derangements of 1..n in lexicographic order, one per request.
//
//   channel   dir   words per request           payload
//   s_axis    in    1                           tdata: restart
//   m_axis    out   n, or 1 when exhausted      tdata: position, value
//                                               tlast: last, tuser: exhausted
//   cfg       in    write only                  cfg_wdata: item_count
//
// a request is taken, then the walk runs its placement and backtrack steps,
// then the result words stream out
// a request after the list has run out skips the walk; one request is in work at a time
// s_axis_tready is high only while idle; m_axis stalls hold the emit, never the walk
// reset clears the walk and sets item_count to 4; a cfg write also restarts
// ----------------------------------------------------------------------------
`default_nettype none

module derangement_enumerator_top import derang_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // restart
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [2*FIELD_W-1:0]      m_axis_tdata,   // position, value
    output logic                      m_axis_tlast,
    output logic                      m_axis_tuser,   // exhausted
    input  wire logic                 cfg_wen,
    input  wire logic [FIELD_W-1:0]   cfg_wdata       // item_count
);

    derang_cmd_t    cmd;
    derang_status_t status;

    derang_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    derang_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .restart   (s_axis_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_exh   (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* sv/derang_checker.sv */
// ----------------------------------------------------------------------------
// derang_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "derangement_enumerator_top_macros.svh"

module derang_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);

    `DERANG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled word changed")
    `DERANG_ASSERT(a_exh_single, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0), "exhausted word malformed")
    `DERANG_ASSERT(a_deranged, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[3:0] != 4'd0) && (m_axis_tdata[7:4] != 4'd0) && (m_axis_tdata[7:4] != m_axis_tdata[3:0]), "value at its own position")
    `DERANG_ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !m_axis_tvalid, "output valid in reset")

endmodule

bind derangement_enumerator_top derang_checker u_derang_checker (.*);

`default_nettype wire

/* tb/sv/tb_derangement_enumerator_top.sv */
// ----------------------------------------------------------------------------
// tb_derangement_enumerator_top
// Self-checking bench for the derangement enumerator: requests go in on
// s_axis, an in-bench backtracking walk predicts every word that must come
// back on m_axis, and each returned word is checked against the oldest
// prediction. Directed runs cover the short lists, count clamping and
// restarts; random runs vary the count and the pacing on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_derangement_enumerator_top import derang_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] value;
        logic               last;
        logic               exhausted;
    } perm_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'd0;    // restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [2*FIELD_W-1:0]   m_axis_tdata;           // position, value
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;           // exhausted
    logic                   cfg_wen = 1'b0;
    logic [FIELD_W-1:0]     cfg_wdata = '0;

    // predictor state
    logic [FIELD_W-1:0]     count_reg;
    logic [FIELD_W-1:0]     slot_vals [MAX_ITEMS_DEF];
    logic [MAX_ITEMS_DEF+1:0] used_vals;
    int                     fill_depth;
    bit                     walk_started;
    bit                     list_done;

    perm_word_t             pending_words [$];
    perm_word_t             got_word;
    perm_word_t             exp_word;
    int                     mismatches = 0;
    int                     idle_pct = 0;
    int                     stall_pct = 0;
    logic                   rx_hold = 1'b0;

    derangement_enumerator_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------ model

    function automatic int active_count();
        int n;
        n = count_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_ITEMS_DEF)
            n = MAX_ITEMS_DEF;
        return n;
    endfunction

    function automatic void clear_walk();
        for (int i = 0; i < MAX_ITEMS_DEF; i++)
            slot_vals[i] = '0;
        used_vals    = '0;
        fill_depth   = 0;
        walk_started = 1'b0;
        list_done    = 1'b0;
    endfunction

    // backtrack from depth d, trying candidates from c upward
    function automatic bit place_values(int n, int d, int c);
        int v;
        bit found;
        bit finished;
        found    = 1'b0;
        finished = 1'b0;
        while (!finished)
        begin
            v = c;
            while (v <= n && (used_vals[v] || v == d + 1))
                v++;
            if (v <= n)
            begin
                slot_vals[d] = FIELD_W'(v);
                used_vals[v] = 1'b1;
                d++;
                c = 1;
                if (d == n)
                begin
                    fill_depth = d;
                    found      = 1'b1;
                    finished   = 1'b1;
                end
            end
            else if (d == 0)
            begin
                fill_depth = 0;
                finished   = 1'b1;
            end
            else
            begin
                d--;
                used_vals[slot_vals[d]] = 1'b0;
                c = slot_vals[d] + 1;
            end
        end
        return found;
    endfunction

    function automatic void predict_request(bit restart);
        int n;
        int d;
        int v;
        bit found;
        perm_word_t w;
        n     = active_count();
        found = 1'b0;
        if (restart)
            clear_walk();
        if (!list_done)
        begin
            if (!walk_started)
            begin
                used_vals    = '0;
                found        = place_values(n, 0, 1);
                walk_started = 1'b1;
            end
            else
            begin
                d = n - 1;
                v = slot_vals[d];
                used_vals[v] = 1'b0;
                found = place_values(n, d, v + 1);
            end
            if (!found)
                list_done = 1'b1;
        end
        if (!found)
        begin
            w = '{position: '0, value: '0, last: 1'b1, exhausted: 1'b1};
            pending_words.push_back(w);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                w.position  = FIELD_W'(i + 1);
                w.value     = slot_vals[i];
                w.last      = (i + 1 == n);
                w.exhausted = 1'b0;
                pending_words.push_back(w);
            end
        end
    endfunction

    // ---------------------------------------------------------------- checker

    function automatic void note_mismatch(string what, perm_word_t e, perm_word_t g);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected pos/val/last/exh %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                     $time, what, e.position, e.value, e.last, e.exhausted,
                     g.position, g.value, g.last, g.exhausted);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_word.position  = m_axis_tdata[FIELD_W-1:0];
            got_word.value     = m_axis_tdata[2*FIELD_W-1:FIELD_W];
            got_word.last      = m_axis_tlast;
            got_word.exhausted = m_axis_tuser;
            if (pending_words.size() == 0)
                note_mismatch("unexpected word", '0, got_word);
            else
            begin
                exp_word = pending_words.pop_front();
                if (exp_word != got_word)
                    note_mismatch("word mismatch", exp_word, got_word);
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);

    // ----------------------------------------------------------------- driver

    task automatic set_pacing(int idle, int stall);
        idle_pct  = idle;
        stall_pct <= stall;
    endtask

    task automatic send_req(bit restart);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(restart);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_count(logic [FIELD_W-1:0] cnt);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge clk);
        count_reg = cnt;
        clear_walk();
        cfg_wen <= 1'b0;
    endtask

    // ------------------------------------------------------------------ tests

    task automatic test_power_on_count();
        repeat (3) send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        wait_drained();
    endtask

    task automatic test_short_lists();
        write_count(4'd1);
        repeat (2) send_req(1'b0);
        write_count(4'd2);
        repeat (3) send_req(1'b0);
        send_req(1'b1);
        write_count(4'd3);
        repeat (3) send_req(1'b0);
        wait_drained();
    endtask

    task automatic test_count_clamp();
        write_count(4'd0);
        send_req(1'b0);
        write_count(4'd15);
        repeat (2) send_req(1'b0);
        write_count(4'd9);
        send_req(1'b0);
        wait_drained();
    endtask

    task automatic test_write_restarts();
        write_count(4'd4);
        repeat (2) send_req(1'b0);
        write_count(4'd4);
        send_req(1'b0);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        set_pacing(0, 0);
        write_count(4'd8);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (10) send_req(1'b0);
        wait_drained();
    endtask

    task automatic test_full_list();
        set_pacing(22, 22);
        write_count(4'd5);
        repeat (48) send_req(1'b0);
        send_req(1'b1);
        wait_drained();
    endtask

    task automatic test_random_walk(int idle, int stall, int budget);
        int left;
        int len;
        int r;
        logic [FIELD_W-1:0] cnt;
        set_pacing(idle, stall);
        left = budget;
        while (left > 0)
        begin
            r = $urandom_range(9);
            if (r < 6)
                cnt = FIELD_W'($urandom_range(4, 8));
            else if (r < 8)
                cnt = FIELD_W'($urandom_range(1, 3));
            else if (r == 8)
                cnt = 4'd0;
            else
                cnt = FIELD_W'($urandom_range(9, 15));
            write_count(cnt);
            len = $urandom_range(8, 30);
            if (len > left)
                len = left;
            repeat (len) send_req($urandom_range(99) < 8);
            left -= len;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        count_reg = ITEM_COUNT_RESET;
        clear_walk();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        set_pacing(0, 0);
        test_power_on_count();
        test_short_lists();
        test_count_clamp();
        test_write_restarts();
        test_output_backpressure();
        test_full_list();
        test_random_walk(0, 0, 70);
        test_random_walk(66, 0, 70);
        test_random_walk(0, 66, 70);
        test_random_walk(22, 22, 70);
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
